// ===== sv/single_wire_climate_sensor_reader_assert.svh =====
// assertion helpers for the sensor reader, clocked on aclk with aresetn
`ifndef SINGLE_WIRE_CLIMATE_SENSOR_READER_ASSERT_SVH
`define SINGLE_WIRE_CLIMATE_SENSOR_READER_ASSERT_SVH

// same-cycle implication
`define SWCR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SWCR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/swcr_pkg.sv =====
package swcr_pkg;

    localparam int FRAME_LEN  = 40;
    localparam int BIT_IDX_W  = 6;
    localparam int PH_W       = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [PH_W-1:0] PH_IDLE     = 3'd0;
    localparam logic [PH_W-1:0] PH_START    = 3'd1;
    localparam logic [PH_W-1:0] PH_RESP_A   = 3'd2;
    localparam logic [PH_W-1:0] PH_RESP_B   = 3'd3;
    localparam logic [PH_W-1:0] PH_RESP_C   = 3'd4;
    localparam logic [PH_W-1:0] PH_BIT_LOW  = 3'd5;
    localparam logic [PH_W-1:0] PH_BIT_HIGH = 3'd6;

    localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_KIND     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_LOW_TICKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_THRESHOLD   = 2'd2;

    localparam logic [15:0] START_LOW_RESET = 16'd20000;
    localparam logic [7:0]  THRESHOLD_RESET = 8'd60;

    typedef struct packed {
        logic        sensor_kind;
        logic [15:0] start_low_ticks;
        logic [7:0]  one_threshold;
    } cfg_t;

    typedef struct packed {
        logic        ok;
        logic [15:0] temperature;
        logic [15:0] humidity;
    } calc_t;

    typedef struct packed {
        logic        drive_low;
        logic        busy;
        logic        frame_done;
        logic        checksum_ok;
        logic [15:0] temperature;
        logic [15:0] humidity;
    } result_t;

endpackage

// ===== sv/swcr_frame_calc.sv =====
module swcr_frame_calc (
    input  logic                     sensor_kind,
    input  logic [39:0]              frame,
    output swcr_pkg::calc_t          calc
);
    import swcr_pkg::*;

    logic [7:0]  b0, b1, b2, b3, b4;
    logic [9:0]  sum;
    logic [15:0] b0w, b1w, b2w, b3w;

    assign b0 = frame[39:32];
    assign b1 = frame[31:24];
    assign b2 = frame[23:16];
    assign b3 = frame[15:8];
    assign b4 = frame[7:0];

    assign b0w = {8'd0, b0};
    assign b1w = {8'd0, b1};
    assign b2w = {8'd0, b2};
    assign b3w = {8'd0, b3};

    assign sum = {2'd0, b0} + {2'd0, b1} + {2'd0, b2} + {2'd0, b3};

    always_comb begin
        calc.ok = (sum[7:0] == b4);
        if (sensor_kind) begin
            calc.humidity    = {b0, b1};
            calc.temperature = {b2, b3};
        end else begin
            // integer * 10 + tenths
            calc.humidity    = (b0w << 3) + (b0w << 1) + b1w;
            calc.temperature = (b2w << 3) + (b2w << 1) + b3w;
        end
    end

endmodule

// ===== sv/swcr_core.sv =====
module swcr_core #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  swcr_pkg::cfg_t    cfg,
    input  logic              step,
    input  logic              command,
    input  logic              line_level,
    output swcr_pkg::result_t res_next
);
    import swcr_pkg::*;

    localparam int EXT_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

    logic [PH_W-1:0]        phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0] tick_reg, tick_next;
    logic [BIT_IDX_W-1:0]   bit_idx_reg, bit_idx_next;
    logic [39:0]            frame_reg, frame_next;
    logic [15:0]            temp_reg, temp_next;
    logic [15:0]            hum_reg, hum_next;
    logic                   ok_reg, ok_next;
    logic                   done;

    logic                   tick_sat;
    logic [COUNT_WIDTH-1:0] tick_inc;
    logic                   start_reached;
    logic                   bit_value;
    logic [39:0]            frame_shift;
    logic [BIT_IDX_W-1:0]   bit_idx_inc;
    calc_t                  calc;

    assign tick_sat      = (tick_reg == {COUNT_WIDTH{1'b1}});
    assign tick_inc      = tick_sat ? tick_reg : tick_reg + 1'b1;
    assign start_reached = (EXT_W'(tick_reg) >= EXT_W'(cfg.start_low_ticks)) || tick_sat;
    assign bit_value     = (tick_reg > COUNT_WIDTH'(cfg.one_threshold));
    assign frame_shift   = {frame_reg[38:0], bit_value};
    assign bit_idx_inc   = bit_idx_reg + 1'b1;

    swcr_frame_calc u_calc (
        .sensor_kind (cfg.sensor_kind),
        .frame       (frame_shift),
        .calc        (calc)
    );

    always_comb begin
        phase_next   = phase_reg;
        tick_next    = tick_reg;
        bit_idx_next = bit_idx_reg;
        frame_next   = frame_reg;
        temp_next    = temp_reg;
        hum_next     = hum_reg;
        ok_next      = ok_reg;
        done         = 1'b0;
        if (step) begin
            if (command) begin
                bit_idx_next = '0;
                frame_next   = '0;
                if (cfg.start_low_ticks == 16'd0) begin
                    phase_next = PH_RESP_A;
                    tick_next  = '0;
                end else begin
                    phase_next = PH_START;
                    tick_next  = COUNT_WIDTH'(1);
                end
            end else begin
                case (phase_reg)
                    PH_IDLE: begin
                        phase_next = PH_IDLE;
                    end
                    PH_START: begin
                        if (start_reached) begin
                            phase_next = PH_RESP_A;
                        end else begin
                            tick_next = tick_inc;
                        end
                    end
                    PH_RESP_A: begin
                        if (!line_level) phase_next = PH_RESP_B;
                    end
                    PH_RESP_B: begin
                        if (line_level) phase_next = PH_RESP_C;
                    end
                    PH_RESP_C: begin
                        if (!line_level) phase_next = PH_BIT_LOW;
                    end
                    PH_BIT_LOW: begin
                        if (line_level) begin
                            phase_next = PH_BIT_HIGH;
                            tick_next  = COUNT_WIDTH'(1);
                        end
                    end
                    PH_BIT_HIGH: begin
                        if (line_level) begin
                            tick_next = tick_inc;
                        end else begin
                            frame_next = frame_shift;
                            if (bit_idx_inc >= BIT_IDX_W'(FRAME_LEN)) begin
                                ok_next = calc.ok;
                                if (calc.ok) begin
                                    temp_next = calc.temperature;
                                    hum_next  = calc.humidity;
                                end
                                done         = 1'b1;
                                phase_next   = PH_IDLE;
                                bit_idx_next = '0;
                            end else begin
                                bit_idx_next = bit_idx_inc;
                                phase_next   = PH_BIT_LOW;
                            end
                        end
                    end
                    default: begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            tick_reg    <= '0;
            bit_idx_reg <= '0;
            frame_reg   <= '0;
            temp_reg    <= '0;
            hum_reg     <= '0;
            ok_reg      <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            tick_reg    <= tick_next;
            bit_idx_reg <= bit_idx_next;
            frame_reg   <= frame_next;
            temp_reg    <= temp_next;
            hum_reg     <= hum_next;
            ok_reg      <= ok_next;
        end
    end

    always_comb begin
        res_next.drive_low   = (phase_next == PH_START);
        res_next.busy        = (phase_next != PH_IDLE);
        res_next.frame_done  = done;
        res_next.checksum_ok = ok_next;
        res_next.temperature = temp_next;
        res_next.humidity    = hum_next;
    end

endmodule

// ===== sv/single_wire_climate_sensor_reader.sv =====
// an accepted word has its result word valid in the result register when it is empty or read
// throughput: one word per cycle while m_ready does not stall, each register holds one word
// the bit-timing state advances when a word leaves the input register for the result register
// reset (aresetn low at a clock edge): both registers empty, read state idle, holds and
// checksum flag zero, registers at kind 0, start low 20000 ticks, threshold 60
`include "single_wire_climate_sensor_reader_assert.svh"

module single_wire_climate_sensor_reader #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_command,
    input  logic                               s_line_level,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_drive_low,
    output logic                               m_busy_res,
    output logic                               m_frame_done,
    output logic                               m_checksum_ok,
    output logic [15:0]                        m_temperature_tenths,
    output logic [15:0]                        m_humidity_tenths,
    input  logic                               cfg_wr_en,
    input  logic [swcr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [swcr_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import swcr_pkg::*;

    cfg_t    cfg_reg;
    logic    in_valid_reg;
    logic    in_cmd_reg;
    logic    in_level_reg;
    logic    out_valid_reg;
    result_t out_res_reg;
    result_t res_next;
    logic    advance;
    logic    step;

    assign advance = !out_valid_reg || m_ready;
    assign step    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sensor_kind     <= 1'b0;
            cfg_reg.start_low_ticks <= START_LOW_RESET;
            cfg_reg.one_threshold   <= THRESHOLD_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_SENSOR_KIND:     cfg_reg.sensor_kind     <= cfg_wdata[0];
                CFG_START_LOW_TICKS: cfg_reg.start_low_ticks <= cfg_wdata[15:0];
                CFG_ONE_THRESHOLD:   cfg_reg.one_threshold   <= cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_cmd_reg   <= s_command;
            in_level_reg <= s_line_level;
        end
    end

    swcr_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .step       (step),
        .command    (in_cmd_reg),
        .line_level (in_level_reg),
        .res_next   (res_next)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_res_reg <= res_next;
        end
    end

    assign m_valid              = out_valid_reg;
    assign m_drive_low          = out_res_reg.drive_low;
    assign m_busy_res           = out_res_reg.busy;
    assign m_frame_done         = out_res_reg.frame_done;
    assign m_checksum_ok        = out_res_reg.checksum_ok;
    assign m_temperature_tenths = out_res_reg.temperature;
    assign m_humidity_tenths    = out_res_reg.humidity;

    `SWCR_ASSERT_NEXT(a_step_fills_out, step, out_valid_reg,
        "word moved out of input register but result register is empty")
    `SWCR_ASSERT_NEXT(a_stall_keeps_in, in_valid_reg && out_valid_reg && !m_ready, in_valid_reg,
        "input word dropped while result register stalled")
    `SWCR_ASSERT_SAME(a_done_not_busy, out_valid_reg && out_res_reg.frame_done,
        !out_res_reg.busy && !out_res_reg.drive_low,
        "frame done word still shows a read in progress")

endmodule

// ===== tb/sv/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import swcr_pkg::*;

    localparam int COUNT_W = 16;
    localparam logic [COUNT_W-1:0] TICK_MAX = '1;

    typedef struct packed {
        logic cmd;
        logic level;
    } tick_word_t;

    typedef enum int {RX_OPEN, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_mode_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic                  s_command = 1'b0;
    logic                  s_line_level = 1'b0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic                  m_drive_low;
    logic                  m_busy_res;
    logic                  m_frame_done;
    logic                  m_checksum_ok;
    logic [15:0]           m_temperature_tenths;
    logic [15:0]           m_humidity_tenths;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    single_wire_climate_sensor_reader #(
        .COUNT_WIDTH(COUNT_W)
    ) dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_command            (s_command),
        .s_line_level         (s_line_level),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_drive_low          (m_drive_low),
        .m_busy_res           (m_busy_res),
        .m_frame_done         (m_frame_done),
        .m_checksum_ok        (m_checksum_ok),
        .m_temperature_tenths (m_temperature_tenths),
        .m_humidity_tenths    (m_humidity_tenths),
        .cfg_wr_en            (cfg_wr_en),
        .cfg_index            (cfg_index),
        .cfg_wdata            (cfg_wdata)
    );

    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    // reader state mirrored from the spec
    cfg_t               sensor_cfg = {1'b0, START_LOW_RESET, THRESHOLD_RESET};
    logic [PH_W-1:0]    rd_phase = PH_IDLE;
    logic [COUNT_W-1:0] ticks = '0;
    int                 bit_cnt = 0;
    logic [39:0]        shift_bits = '0;
    logic [15:0]        temp_hold = '0;
    logic [15:0]        hum_hold = '0;
    logic               sum_ok = 1'b0;

    tick_word_t pending_ticks[$];
    result_t    expected_results[$];

    int words_queued = 0;
    int results_checked = 0;
    int frames_seen = 0;
    int frames_good = 0;
    int reg_writes = 0;
    int mismatches = 0;
    int burst_left = 0;
    int gap_left = 0;
    int stall_left = 0;
    rx_mode_t stall_mode = RX_OPEN;

    function automatic result_t reader_step(input logic cmd, input logic level);
        result_t    r;
        logic [7:0] b0, b1, b2, b3, chk, sum;
        logic       done;
        done = 1'b0;
        if (cmd) begin
            bit_cnt = 0;
            shift_bits = '0;
            if (sensor_cfg.start_low_ticks == 0) begin
                rd_phase = PH_RESP_A;
                ticks = '0;
            end else begin
                rd_phase = PH_START;
                ticks = 1;
            end
        end else begin
            case (rd_phase)
                PH_START: begin
                    if (ticks >= sensor_cfg.start_low_ticks || ticks == TICK_MAX)
                        rd_phase = PH_RESP_A;
                    else
                        ticks++;
                end
                PH_RESP_A: if (!level) rd_phase = PH_RESP_B;
                PH_RESP_B: if (level) rd_phase = PH_RESP_C;
                PH_RESP_C: if (!level) rd_phase = PH_BIT_LOW;
                PH_BIT_LOW: begin
                    if (level) begin
                        rd_phase = PH_BIT_HIGH;
                        ticks = 1;
                    end
                end
                PH_BIT_HIGH: begin
                    if (level) begin
                        if (ticks != TICK_MAX) ticks++;
                    end else begin
                        shift_bits = {shift_bits[38:0], ticks > sensor_cfg.one_threshold};
                        bit_cnt++;
                        if (bit_cnt >= FRAME_LEN) begin
                            {b0, b1, b2, b3, chk} = shift_bits;
                            sum = b0 + b1 + b2 + b3;
                            sum_ok = (sum == chk);
                            if (sum_ok) begin
                                if (sensor_cfg.sensor_kind) begin
                                    hum_hold = {b0, b1};
                                    temp_hold = {b2, b3};
                                end else begin
                                    hum_hold = 16'(b0) * 16'd10 + 16'(b1);
                                    temp_hold = 16'(b2) * 16'd10 + 16'(b3);
                                end
                            end
                            done = 1'b1;
                            rd_phase = PH_IDLE;
                            bit_cnt = 0;
                        end else begin
                            rd_phase = PH_BIT_LOW;
                        end
                    end
                end
                default: rd_phase = PH_IDLE;
            endcase
        end
        r.drive_low = (rd_phase == PH_START);
        r.busy = (rd_phase != PH_IDLE);
        r.frame_done = done;
        r.checksum_ok = sum_ok;
        r.temperature = temp_hold;
        r.humidity = hum_hold;
        return r;
    endfunction

    function automatic void push_tick(input logic cmd, input logic level);
        pending_ticks.push_back(tick_word_t'{cmd, level});
        words_queued++;
    endfunction

    function automatic void push_level(input logic level, input int n);
        repeat (n) push_tick(1'b0, level);
    endfunction

    function automatic logic [39:0] make_frame(input logic good);
        logic [7:0] b0, b1, b2, b3, chk;
        b0 = 8'($urandom_range(0, 255));
        b1 = 8'($urandom_range(0, 255));
        b2 = 8'($urandom_range(0, 255));
        b3 = 8'($urandom_range(0, 255));
        chk = b0 + b1 + b2 + b3;
        if (!good) chk = chk + 8'($urandom_range(1, 255));
        return {b0, b1, b2, b3, chk};
    endfunction

    // start pulse, sensor response, then n_bits timed high pulses
    function automatic void queue_read(input logic [39:0] bits, input int n_bits,
                                       input int first_pulse);
        int thr;
        int k;
        thr = sensor_cfg.one_threshold;
        push_tick(1'b1, 1'($urandom_range(0, 1)));
        repeat (sensor_cfg.start_low_ticks) push_tick(1'b0, 1'($urandom_range(0, 1)));
        push_level(1'b1, $urandom_range(0, 2));
        push_level(1'b0, $urandom_range(1, 3));
        push_level(1'b1, $urandom_range(1, 3));
        push_level(1'b0, $urandom_range(1, 3));
        for (int i = 0; i < n_bits; i++) begin
            if (i == 0 && first_pulse > 0)
                k = first_pulse;
            else if (bits[39-i])
                k = thr + $urandom_range(1, 3);
            else
                k = (thr == 0) ? $urandom_range(1, 3) : $urandom_range(1, thr);
            push_level(1'b1, k);
            push_level(1'b0, $urandom_range(1, 3));
        end
    endfunction

    task automatic program_reg(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        case (idx)
            CFG_SENSOR_KIND:     sensor_cfg.sensor_kind = data[0];
            CFG_START_LOW_TICKS: sensor_cfg.start_low_ticks = data;
            CFG_ONE_THRESHOLD:   sensor_cfg.one_threshold = data[7:0];
            default: ;
        endcase
        reg_writes++;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_quiet();
        do begin
            while (pending_ticks.size() != 0 || s_valid || expected_results.size() != 0)
                @(posedge aclk);
            repeat (4) @(posedge aclk);
        end while (pending_ticks.size() != 0 || s_valid || expected_results.size() != 0);
    endtask

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // driver: bursts of words with random gaps
    always @(posedge aclk) begin
        tick_word_t w;
        logic took;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            took = s_valid && s_ready;
            if (took) expected_results.push_back(reader_step(s_command, s_line_level));
            if (!s_valid || took) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_ticks.size() != 0) begin
                    w = pending_ticks.pop_front();
                    s_valid <= 1'b1;
                    s_command <= w.cmd;
                    s_line_level <= w.level;
                    if (burst_left == 0) begin
                        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                                                 : $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (stall_left == 0) begin
                stall_mode = rx_mode_t'($urandom_range(0, 3));
                stall_left = $urandom_range(16, 256);
            end
            stall_left--;
            case (stall_mode)
                RX_OPEN:     m_ready <= 1'b1;
                RX_COIN:     m_ready <= 1'($urandom_range(0, 1));
                RX_PERIODIC: m_ready <= (stall_left % 4) != 0;
                default:     m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // monitor
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_checked++;
            if (m_frame_done === 1'b1) begin
                frames_seen++;
                if (m_checksum_ok === 1'b1) frames_good++;
            end
            if (expected_results.size() == 0) begin
                $error("result word with nothing expected");
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                check_field("drive_low", 16'(want.drive_low), 16'(m_drive_low));
                check_field("busy_res", 16'(want.busy), 16'(m_busy_res));
                check_field("frame_done", 16'(want.frame_done), 16'(m_frame_done));
                check_field("checksum_ok", 16'(want.checksum_ok), 16'(m_checksum_ok));
                check_field("temperature_tenths", want.temperature, m_temperature_tenths);
                check_field("humidity_tenths", want.humidity, m_humidity_tenths);
            end
        end
    end

    initial begin
        logic [15:0] word;
        logic [39:0] bits;
        int target;
        int pick;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // idle words at reset settings
        push_tick(1'b0, 1'b0);
        push_tick(1'b0, 1'b1);
        push_tick(1'b0, 1'b1);
        push_tick(1'b0, 1'b0);
        wait_quiet();

        // zero start pulse, zero threshold: every bit reads one, checksum fails
        word = 16'($urandom);
        word[0] = 1'b0;
        program_reg(CFG_SENSOR_KIND, word);
        program_reg(CFG_START_LOW_TICKS, 16'd0);
        program_reg(CFG_ONE_THRESHOLD, {8'($urandom), 8'd0});
        queue_read(make_frame(1'b1), 40, 0);
        push_level(1'b1, 2);
        wait_quiet();

        // largest tenths bytes, all-zero frame, new command mid-read
        program_reg(CFG_ONE_THRESHOLD, 16'd1);
        queue_read(40'hFF_FF_FF_FF_FC, 40, 0);
        queue_read(40'h00_00_00_00_00, 40, 0);
        queue_read(make_frame(1'b1), 5, 0);
        queue_read(make_frame(1'b1), 40, 0);
        wait_quiet();

        // long start pulse, long first pulse, signed words
        program_reg(CFG_SENSOR_KIND, 16'hFFFF);
        program_reg(CFG_START_LOW_TICKS, 16'd40);
        program_reg(CFG_ONE_THRESHOLD, {8'($urandom), 8'd2});
        do bits = make_frame(1'b1); while (!bits[39]);
        queue_read(bits, 40, 80);
        push_level(1'b0, 3);
        wait_quiet();

        for (int p = 0; p < 2; p++) begin
            word = 16'($urandom);
            word[0] = p[0];
            program_reg(CFG_SENSOR_KIND, word);
            program_reg(CFG_START_LOW_TICKS, (p == 1) ? 16'd0 : 16'($urandom_range(1, 6)));
            program_reg(CFG_ONE_THRESHOLD, 16'($urandom_range(1, 5)));
            target = words_queued + 80;
            while (words_queued < target) begin
                pick = $urandom_range(0, 9);
                if (pick < 6) begin
                    queue_read(make_frame(pick < 5), 40, 0);
                    push_level(1'($urandom_range(0, 1)), $urandom_range(0, 3));
                end else if (pick < 8) begin
                    queue_read(make_frame(1'b1), $urandom_range(0, 39), 0);
                end else begin
                    repeat ($urandom_range(1, 12)) push_tick(1'b0, 1'($urandom_range(0, 1)));
                end
            end
            queue_read(make_frame(1'b1), 40, 0);
            push_level(1'b1, 3);
            wait_quiet();
        end

        $display("checked %0d result words from %0d input words, %0d register writes",
                 results_checked, words_queued, reg_writes);
        $display("%0d frames decoded, %0d with a good checksum", frames_seen, frames_good);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #30_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/swcr_pkg.sv
sv/swcr_frame_calc.sv
sv/swcr_core.sv
sv/single_wire_climate_sensor_reader.sv
tb/sv/tb.sv
